### hw/rtl/saph_pkg.sv
package saph_pkg;

    // Field widths
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned LETTER_W = 5;
    localparam int unsigned POS_W    = 13;
    localparam int unsigned STATUS_W = 2;

    // Hash arithmetic
    localparam int unsigned HASH_W  = 30;
    localparam int unsigned PROD_W  = 2 * HASH_W;
    localparam int unsigned MU_W    = HASH_W + 1;
    localparam int unsigned RED_W   = 32;
    localparam int unsigned PRIME_W = 7;

    localparam logic [HASH_W-1:0] HASH_MOD     = 30'd1000000007;
    localparam logic [RED_W-1:0]  HASH_MOD_X1  = 32'd1000000007;
    localparam logic [RED_W-1:0]  HASH_MOD_X2  = 32'd2000000014;

    // Barrett factor floor(2^60 / modulus)
    localparam logic [63:0]     BARRETT_MU_WIDE = 64'h1000_0000_0000_0000 / 64'd1000000007;
    localparam logic [MU_W-1:0] BARRETT_MU      = BARRETT_MU_WIDE[MU_W-1:0];

    // Multiply-reduce pipeline latency, operands to reduced result
    localparam int unsigned PIPE_DEPTH = 4;
    localparam int unsigned CNT_W      = $clog2(PIPE_DEPTH);

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND_A = 2'd0,
        MODE_APPEND_B = 2'd1,
        MODE_QUERY    = 2'd2,
        MODE_CLEAR    = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RD_NONE   = 2'd0,
        RD_PAIR1  = 2'd1,
        RD_PAIR2  = 2'd2,
        RD_APPEND = 2'd3
    } rd_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE         = 3'd0,
        ST_DISPATCH     = 3'd1,
        ST_QUERY_RD2    = 3'd2,
        ST_QUERY_WAIT   = 3'd3,
        ST_QUERY_CMP    = 3'd4,
        ST_APPEND_WAIT  = 3'd5,
        ST_APPEND_WRITE = 3'd6
    } state_t;

    typedef struct packed {
        logic    capture;
        rd_sel_t rd_sel;
        logic    write_en;
        logic    clear;
        logic    load_lhs;
        logic    reply;
        status_t reply_status;
        logic    reply_match;
    } ctl_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  full;
        logic  range_ok;
    } dp_stat_t;

    function automatic logic [PRIME_W-1:0] letter_prime(input logic [LETTER_W-1:0] letter);
        logic [PRIME_W-1:0] p;
        unique case (letter)
            5'd0:    p = 7'd2;
            5'd1:    p = 7'd3;
            5'd2:    p = 7'd5;
            5'd3:    p = 7'd7;
            5'd4:    p = 7'd11;
            5'd5:    p = 7'd13;
            5'd6:    p = 7'd17;
            5'd7:    p = 7'd19;
            5'd8:    p = 7'd23;
            5'd9:    p = 7'd29;
            5'd10:   p = 7'd31;
            5'd11:   p = 7'd37;
            5'd12:   p = 7'd41;
            5'd13:   p = 7'd43;
            5'd14:   p = 7'd47;
            5'd15:   p = 7'd53;
            5'd16:   p = 7'd59;
            5'd17:   p = 7'd61;
            5'd18:   p = 7'd67;
            5'd19:   p = 7'd71;
            5'd20:   p = 7'd73;
            5'd21:   p = 7'd79;
            5'd22:   p = 7'd83;
            5'd23:   p = 7'd89;
            5'd24:   p = 7'd97;
            default: p = 7'd101;   // z, and letter codes past z saturate to z
        endcase
        return p;
    endfunction

endpackage

### hw/rtl/saph_ram.sv
module saph_ram #(
    parameter int unsigned WIDTH = 30,
    parameter int unsigned DEPTH = 4097
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/saph_dp.sv
module saph_dp #(
    parameter int unsigned MAX_LEN = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [saph_pkg::MODE_W-1:0]       mode,
    input  logic [saph_pkg::LETTER_W-1:0]     letter,
    input  logic [saph_pkg::POS_W-1:0]        a_start,
    input  logic [saph_pkg::POS_W-1:0]        a_end,
    input  logic [saph_pkg::POS_W-1:0]        b_start,
    input  logic [saph_pkg::POS_W-1:0]        b_end,
    input  saph_pkg::ctl_cmd_t                cmd,
    output saph_pkg::dp_stat_t                stat,
    output logic                              done,
    output logic [saph_pkg::STATUS_W-1:0]     status,
    output logic                              match
);

    localparam int unsigned LEN_W  = $clog2(MAX_LEN + 1);
    localparam int unsigned ADDR_W = LEN_W;
    localparam int unsigned CMP_W  = (LEN_W > saph_pkg::POS_W) ? LEN_W : saph_pkg::POS_W;
    localparam int unsigned HW     = saph_pkg::HASH_W;
    localparam int unsigned PW     = saph_pkg::PROD_W;
    localparam int unsigned MW     = saph_pkg::MU_W;
    localparam int unsigned RW     = saph_pkg::RED_W;
    localparam int unsigned POS_W  = saph_pkg::POS_W;

    // Captured item
    saph_pkg::mode_t                  mode_reg;
    logic [saph_pkg::PRIME_W-1:0]     prime_reg;
    logic [POS_W-1:0]                 a_start_reg;
    logic [POS_W-1:0]                 a_end_reg;
    logic [POS_W-1:0]                 b_start_reg;
    logic [POS_W-1:0]                 b_end_reg;

    logic [LEN_W-1:0]                 len_a_reg;
    logic [LEN_W-1:0]                 len_b_reg;

    logic [ADDR_W-1:0]                a_raddr;
    logic [ADDR_W-1:0]                b_raddr;
    logic                             a_zero_reg;
    logic                             b_zero_reg;
    logic [HW-1:0]                    ram_a_rdata;
    logic [HW-1:0]                    ram_b_rdata;
    logic [HW-1:0]                    rd_a_val;
    logic [HW-1:0]                    rd_b_val;
    logic                             we_a;
    logic                             we_b;

    // Multiply-reduce pipeline
    logic [HW-1:0]                    op_x;
    logic [HW-1:0]                    op_y;
    logic [PW-1:0]                    prod_next;
    logic [PW-1:0]                    prod_reg;
    logic [MW+MW-1:0]                 quo_wide;
    logic [MW-1:0]                    q_reg;
    logic [RW-1:0]                    xlo1_reg;
    logic [MW+HW-1:0]                 qp_wide;
    logic [RW-1:0]                    qp_lo_reg;
    logic [RW-1:0]                    xlo2_reg;
    logic [RW-1:0]                    rem;
    logic [HW-1:0]                    res_next;
    logic [HW-1:0]                    res_reg;
    logic [HW-1:0]                    lhs_reg;

    logic                             a_ok;
    logic                             b_ok;
    logic [LEN_W-1:0]                 len_tgt;

    logic                             done_reg;
    saph_pkg::status_t                status_reg;
    logic                             match_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg    <= saph_pkg::mode_t'(mode);
            prime_reg   <= saph_pkg::letter_prime(letter);
            a_start_reg <= a_start;
            a_end_reg   <= a_end;
            b_start_reg <= b_start;
            b_end_reg   <= b_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg <= '0;
            len_b_reg <= '0;
        end
        else if (cmd.clear)
        begin
            len_a_reg <= '0;
            len_b_reg <= '0;
        end
        else if (cmd.write_en)
        begin
            if (mode_reg == saph_pkg::MODE_APPEND_B)
            begin
                len_b_reg <= len_b_reg + LEN_W'(1);
            end
            else
            begin
                len_a_reg <= len_a_reg + LEN_W'(1);
            end
        end
    end

    // Status for the controller
    assign len_tgt = (mode_reg == saph_pkg::MODE_APPEND_B) ? len_b_reg : len_a_reg;
    assign a_ok = (a_start_reg != '0) && (a_start_reg <= a_end_reg)
                  && (CMP_W'(a_end_reg) <= CMP_W'(len_a_reg));
    assign b_ok = (b_start_reg != '0) && (b_start_reg <= b_end_reg)
                  && (CMP_W'(b_end_reg) <= CMP_W'(len_b_reg));

    assign stat.mode     = mode_reg;
    assign stat.full     = (len_tgt == LEN_W'(MAX_LEN));
    assign stat.range_ok = a_ok && b_ok;

    // Read address select
    always_comb
    begin
        unique case (cmd.rd_sel)
            saph_pkg::RD_PAIR1:
            begin
                a_raddr = ADDR_W'(a_end_reg);
                b_raddr = ADDR_W'(b_start_reg - POS_W'(1));
            end
            saph_pkg::RD_PAIR2:
            begin
                a_raddr = ADDR_W'(a_start_reg - POS_W'(1));
                b_raddr = ADDR_W'(b_end_reg);
            end
            saph_pkg::RD_APPEND:
            begin
                a_raddr = len_a_reg;
                b_raddr = len_b_reg;
            end
            default:
            begin
                a_raddr = '0;
                b_raddr = '0;
            end
        endcase
    end

    // Entry zero is never written; it reads as one
    always_ff @(posedge clk)
    begin
        a_zero_reg <= (a_raddr == '0);
        b_zero_reg <= (b_raddr == '0);
    end

    assign we_a = cmd.write_en && (mode_reg == saph_pkg::MODE_APPEND_A);
    assign we_b = cmd.write_en && (mode_reg == saph_pkg::MODE_APPEND_B);

    saph_ram #(
        .WIDTH (HW),
        .DEPTH (MAX_LEN + 1)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (len_a_reg + LEN_W'(1)),
        .wdata (res_reg),
        .raddr (a_raddr),
        .rdata (ram_a_rdata)
    );

    saph_ram #(
        .WIDTH (HW),
        .DEPTH (MAX_LEN + 1)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (len_b_reg + LEN_W'(1)),
        .wdata (res_reg),
        .raddr (b_raddr),
        .rdata (ram_b_rdata)
    );

    assign rd_a_val = a_zero_reg ? HW'(1) : ram_a_rdata;
    assign rd_b_val = b_zero_reg ? HW'(1) : ram_b_rdata;

    // Operands: append multiplies the tail product by the letter prime,
    // query multiplies one A entry by one B entry
    assign op_x = (mode_reg == saph_pkg::MODE_APPEND_B) ? rd_b_val : rd_a_val;
    assign op_y = (mode_reg == saph_pkg::MODE_QUERY) ? rd_b_val : HW'(prime_reg);

    assign prod_next = op_x * op_y;
    assign quo_wide  = prod_reg[PW-1:HW-1] * saph_pkg::BARRETT_MU;
    assign qp_wide   = q_reg * saph_pkg::HASH_MOD;

    // Barrett remainder stays below three moduli
    assign rem = xlo2_reg - qp_lo_reg;

    always_comb
    begin
        if (rem >= saph_pkg::HASH_MOD_X2)
        begin
            res_next = HW'(rem - saph_pkg::HASH_MOD_X2);
        end
        else if (rem >= saph_pkg::HASH_MOD_X1)
        begin
            res_next = HW'(rem - saph_pkg::HASH_MOD_X1);
        end
        else
        begin
            res_next = HW'(rem);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        q_reg     <= quo_wide[MW+MW-1:HW+1];
        xlo1_reg  <= prod_reg[RW-1:0];
        qp_lo_reg <= qp_wide[RW-1:0];
        xlo2_reg  <= xlo1_reg;
        res_reg   <= res_next;
        if (cmd.load_lhs)
        begin
            lhs_reg <= res_reg;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.reply;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.reply)
        begin
            status_reg <= cmd.reply_status;
            match_reg  <= cmd.reply_match && (lhs_reg == res_reg);
        end
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign match  = match_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (len_a_reg <= LEN_W'(MAX_LEN)) && (len_b_reg <= LEN_W'(MAX_LEN)))
        else $error("string length past capacity");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_en |-> !stat.full)
        else $error("append written into a full store");

endmodule

### hw/rtl/saph_ctrl.sv
module saph_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  saph_pkg::dp_stat_t stat,
    output saph_pkg::ctl_cmd_t cmd,
    output logic               busy
);

    localparam int unsigned CW = saph_pkg::CNT_W;

    saph_pkg::state_t state_reg;
    saph_pkg::state_t state_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic             cnt_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= saph_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign cnt_last = (cnt_reg == CW'(saph_pkg::PIPE_DEPTH - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            saph_pkg::ST_IDLE:
            begin
                cmd.capture = start;
                if (start)
                begin
                    state_next = saph_pkg::ST_DISPATCH;
                end
            end
            saph_pkg::ST_DISPATCH:
            begin
                unique case (stat.mode) inside
                    saph_pkg::MODE_APPEND_A, saph_pkg::MODE_APPEND_B:
                    begin
                        if (stat.full)
                        begin
                            cmd.reply        = 1'b1;
                            cmd.reply_status = saph_pkg::STATUS_FULL;
                            state_next       = saph_pkg::ST_IDLE;
                        end
                        else
                        begin
                            cmd.rd_sel = saph_pkg::RD_APPEND;
                            cnt_next   = '0;
                            state_next = saph_pkg::ST_APPEND_WAIT;
                        end
                    end
                    saph_pkg::MODE_QUERY:
                    begin
                        if (!stat.range_ok)
                        begin
                            cmd.reply        = 1'b1;
                            cmd.reply_status = saph_pkg::STATUS_RANGE;
                            state_next       = saph_pkg::ST_IDLE;
                        end
                        else
                        begin
                            cmd.rd_sel = saph_pkg::RD_PAIR1;
                            state_next = saph_pkg::ST_QUERY_RD2;
                        end
                    end
                    default:
                    begin
                        cmd.clear        = 1'b1;
                        cmd.reply        = 1'b1;
                        cmd.reply_status = saph_pkg::STATUS_OK;
                        state_next       = saph_pkg::ST_IDLE;
                    end
                endcase
            end
            saph_pkg::ST_QUERY_RD2:
            begin
                cmd.rd_sel = saph_pkg::RD_PAIR2;
                cnt_next   = '0;
                state_next = saph_pkg::ST_QUERY_WAIT;
            end
            saph_pkg::ST_QUERY_WAIT:
            begin
                // lhs trails rhs by one stage; the last load keeps lhs
                cmd.load_lhs = 1'b1;
                if (cnt_last)
                begin
                    state_next = saph_pkg::ST_QUERY_CMP;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            saph_pkg::ST_QUERY_CMP:
            begin
                cmd.reply        = 1'b1;
                cmd.reply_status = saph_pkg::STATUS_OK;
                cmd.reply_match  = 1'b1;
                state_next       = saph_pkg::ST_IDLE;
            end
            saph_pkg::ST_APPEND_WAIT:
            begin
                if (cnt_last)
                begin
                    state_next = saph_pkg::ST_APPEND_WRITE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            saph_pkg::ST_APPEND_WRITE:
            begin
                cmd.write_en     = 1'b1;
                cmd.reply        = 1'b1;
                cmd.reply_status = saph_pkg::STATUS_OK;
                state_next       = saph_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = saph_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != saph_pkg::ST_IDLE);

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == saph_pkg::ST_IDLE && start) |=> (state_reg == saph_pkg::ST_DISPATCH))
        else $error("accepted item not dispatched");

    a_reply_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.reply |=> (state_reg == saph_pkg::ST_IDLE))
        else $error("controller still busy after reply");

endmodule

### hw/rtl/substring_anagram_prime_hash.sv
// Substring anagram checker over two strings built one letter at a time.
// Pulse start with busy low to hand over one item; exactly one result comes
// back later as a one-cycle pulse on done with status and match, and there is
// no backpressure, so the receiver must take it in that cycle. A clear, a
// full-store append or a bad query range is answered from the dispatch state.
// An append or a query goes through the registered memory read and the
// four-stage multiply-and-reduce pipeline (product, Barrett quotient,
// quotient times modulus, final correction); a query pushes its two cross
// products through it back to back. Entry zero of each store reads as one
// without being stored, so no clearing pass runs after reset and the block
// is ready at once.
module substring_anagram_prime_hash #(
    parameter int unsigned MAX_LEN = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [saph_pkg::MODE_W-1:0]   mode,
    input  logic [saph_pkg::LETTER_W-1:0] letter,
    input  logic [saph_pkg::POS_W-1:0]    a_start,
    input  logic [saph_pkg::POS_W-1:0]    a_end,
    input  logic [saph_pkg::POS_W-1:0]    b_start,
    input  logic [saph_pkg::POS_W-1:0]    b_end,
    output logic                          done,
    output logic [saph_pkg::STATUS_W-1:0] status,
    output logic                          match
);

    // Commands from the sequencer, status back from the datapath
    saph_pkg::ctl_cmd_t cmd;
    saph_pkg::dp_stat_t stat;

    // Sequence each item: check length or range, issue reads, wait out the
    // multiply pipeline, then write the new prefix product or compare, or clear.
    saph_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Hold the two prefix-product stores, the lengths, the shared modular
    // multiplier and the result register.
    saph_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .mode    (mode),
        .letter  (letter),
        .a_start (a_start),
        .a_end   (a_end),
        .b_start (b_start),
        .b_end   (b_end),
        .cmd     (cmd),
        .stat    (stat),
        .done    (done),
        .status  (status),
        .match   (match)
    );

endmodule
